// ===== hdl/blob_extent_centroid_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the blob extent and centroid accumulator.
// Each macro expects signals named clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef BLOB_EXTENT_CENTROID_ACCUMULATOR_DEFINES_SVH
`define BLOB_EXTENT_CENTROID_ACCUMULATOR_DEFINES_SVH

// Condition in this cycle implies consequence in the same cycle
`define BECA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in this cycle implies consequence in the next cycle
`define BECA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/beca_pkg.sv =====
// ----------------------------------------------------------------------------
// beca_pkg
// Shared action codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package beca_pkg;

	// Input action codes
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REPORT = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic add;        // fold the input point into the region
		logic clr;        // empty the region
		logic snap;       // copy region statistics into the report registers
		logic div_start;  // launch one centroid division
		logic div_sel;    // 0 column sum, 1 row sum
		logic cap_x;      // store the quotient as centroid x
		logic cap_y;      // store the quotient as centroid y
		logic load;       // move the report into the output registers
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;      // live region holds no point
		logic div_done;   // divider quotient ready this cycle
	} stat_t;

endpackage

// ===== hdl/blob_extent_centroid_accumulator.sv =====
// ----------------------------------------------------------------------------
// blob_extent_centroid_accumulator
// Bounding extremes, saturating area and fixed-point centroid of a pixel
// region, built from a controller and a datapath with an iterative divider.
//
//   channel  signals                               role
//   in       in_valid, in_ready, action, x, y      add / report / clear
//   out      out_valid, out_ready, area ..         one descriptor per report
//
// Add and clear items are taken while idle, so points stream at one a cycle
// between reports. A report on a non-empty region holds the input while the
// shared divider retires one quotient bit a cycle, first for the column sum,
// then for the row sum. An empty report skips the divider. Reset empties the
// region and drops out_valid.
// A waiting result holds the next report in its last cycle, and the input
// with it; points and clears ahead of that report go on.
// ----------------------------------------------------------------------------
module blob_extent_centroid_accumulator #(
	parameter int COORD_BITS = 12,
	parameter int AREA_BITS  = 24,
	parameter int FRAC_BITS  = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [COORD_BITS-1:0]           x,
	input  logic [COORD_BITS-1:0]           y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [AREA_BITS-1:0]            area,
	output logic [COORD_BITS-1:0]           left_x,
	output logic [COORD_BITS-1:0]           left_y,
	output logic [COORD_BITS-1:0]           right_x,
	output logic [COORD_BITS-1:0]           right_y,
	output logic [COORD_BITS-1:0]           top_x,
	output logic [COORD_BITS-1:0]           top_y,
	output logic [COORD_BITS-1:0]           bottom_x,
	output logic [COORD_BITS-1:0]           bottom_y,
	output logic [COORD_BITS+FRAC_BITS-1:0] centroid_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] centroid_y,
	output logic                            empty_res
);

	beca_pkg::cmd_t  cmd;
	beca_pkg::stat_t stat;

	beca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	beca_dp #(
		.COORD_BITS(COORD_BITS),
		.AREA_BITS (AREA_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.x         (x),
		.y         (y),
		.area      (area),
		.left_x    (left_x),
		.left_y    (left_y),
		.right_x   (right_x),
		.right_y   (right_y),
		.top_x     (top_x),
		.top_y     (top_y),
		.bottom_x  (bottom_x),
		.bottom_y  (bottom_y),
		.centroid_x(centroid_x),
		.centroid_y(centroid_y),
		.empty_res (empty_res)
	);

endmodule

// ===== hdl/beca_div.sv =====
// ----------------------------------------------------------------------------
// beca_div
// Restoring divider, one quotient bit per cycle. The dividend's upper bits
// must already be below the divisor, so only QUO_BITS steps are needed.
// ----------------------------------------------------------------------------
module beca_div #(
	parameter int AREA_BITS = 24,
	parameter int QUO_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [AREA_BITS+QUO_BITS-1:0] dividend,
	input  logic [AREA_BITS-1:0]          divisor,
	output logic                          busy,
	output logic                          done,
	output logic [QUO_BITS-1:0]           quotient
);

	localparam int CNT_BITS = $clog2(QUO_BITS + 1);

	logic [AREA_BITS-1:0] rem_q;
	logic [AREA_BITS-1:0] dvs_q;
	logic [QUO_BITS-1:0]  num_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [AREA_BITS:0]   trial;
	logic [AREA_BITS:0]   diff;
	logic                 fits;

	// Trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, num_q[QUO_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUO_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then retire one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= dividend[AREA_BITS+QUO_BITS-1:QUO_BITS];
			num_q <= dividend[QUO_BITS-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[AREA_BITS-1:0] : trial[AREA_BITS-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/beca_dp.sv =====
// ----------------------------------------------------------------------------
// beca_dp
// Region datapath: extreme points, saturating count, coordinate sums,
// report snapshot, centroid divider and output registers.
// ----------------------------------------------------------------------------
module beca_dp #(
	parameter int COORD_BITS = 12,
	parameter int AREA_BITS  = 24,
	parameter int FRAC_BITS  = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  beca_pkg::cmd_t                cmd,
	output beca_pkg::stat_t               stat,
	input  logic [COORD_BITS-1:0]         x,
	input  logic [COORD_BITS-1:0]         y,
	output logic [AREA_BITS-1:0]          area,
	output logic [COORD_BITS-1:0]         left_x,
	output logic [COORD_BITS-1:0]         left_y,
	output logic [COORD_BITS-1:0]         right_x,
	output logic [COORD_BITS-1:0]         right_y,
	output logic [COORD_BITS-1:0]         top_x,
	output logic [COORD_BITS-1:0]         top_y,
	output logic [COORD_BITS-1:0]         bottom_x,
	output logic [COORD_BITS-1:0]         bottom_y,
	output logic [COORD_BITS+FRAC_BITS-1:0] centroid_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] centroid_y,
	output logic                          empty_res
);

	localparam int SUM_BITS = COORD_BITS + AREA_BITS;
	localparam int QUO_BITS = COORD_BITS + FRAC_BITS;
	localparam int DVD_BITS = AREA_BITS + QUO_BITS;

	// Live region state
	logic [AREA_BITS-1:0]  count_q;
	logic                  any_q;
	logic [COORD_BITS-1:0] ext_q [8];
	logic [SUM_BITS-1:0]   csum_q;
	logic [SUM_BITS-1:0]   rsum_q;

	// Report snapshot
	logic [AREA_BITS-1:0]  rep_area_q;
	logic [COORD_BITS-1:0] rep_ext_q [8];
	logic [SUM_BITS-1:0]   rep_csum_q;
	logic [SUM_BITS-1:0]   rep_rsum_q;
	logic                  rep_empty_q;
	logic [QUO_BITS-1:0]   cx_q;
	logic [QUO_BITS-1:0]   cy_q;

	// Output registers
	logic [AREA_BITS-1:0]  area_q;
	logic [COORD_BITS-1:0] out_ext_q [8];
	logic [QUO_BITS-1:0]   out_cx_q;
	logic [QUO_BITS-1:0]   out_cy_q;
	logic                  empty_q;

	logic                  upd_left;
	logic                  upd_right;
	logic                  upd_top;
	logic                  upd_bottom;
	logic                  live_empty;
	logic [DVD_BITS-1:0]   dividend;
	logic                  div_busy;
	logic                  div_done;
	logic [QUO_BITS-1:0]   quotient;

	// Strict compares keep the earlier point on ties; first point takes all
	assign upd_left   = !any_q || (x < ext_q[0]);
	assign upd_right  = !any_q || (x > ext_q[2]);
	assign upd_top    = !any_q || (y < ext_q[5]);
	assign upd_bottom = !any_q || (y > ext_q[7]);
	assign live_empty = !any_q || (count_q == '0);

	// Update or clear the region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			any_q   <= 1'b0;
			csum_q  <= '0;
			rsum_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				ext_q[i] <= '0;
			end
		end else if (cmd.clr) begin
			count_q <= '0;
			any_q   <= 1'b0;
			csum_q  <= '0;
			rsum_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				ext_q[i] <= '0;
			end
		end else if (cmd.add) begin
			any_q <= 1'b1;
			if (upd_left) begin
				ext_q[0] <= x;
				ext_q[1] <= y;
			end
			if (upd_right) begin
				ext_q[2] <= x;
				ext_q[3] <= y;
			end
			if (upd_top) begin
				ext_q[4] <= x;
				ext_q[5] <= y;
			end
			if (upd_bottom) begin
				ext_q[6] <= x;
				ext_q[7] <= y;
			end
			// Freeze count and sums once the count saturates
			if (count_q != {AREA_BITS{1'b1}}) begin
				count_q <= count_q + 1'b1;
				csum_q  <= csum_q + SUM_BITS'(x);
				rsum_q  <= rsum_q + SUM_BITS'(y);
			end
		end
	end

	// Capture the report snapshot and the centroid quotients
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			rep_area_q  <= count_q;
			rep_csum_q  <= csum_q;
			rep_rsum_q  <= rsum_q;
			rep_empty_q <= live_empty;
			for (int i = 0; i < 8; i++) begin
				rep_ext_q[i] <= ext_q[i];
			end
		end
		if (cmd.cap_x) begin
			cx_q <= quotient;
		end
		if (cmd.cap_y) begin
			cy_q <= quotient;
		end
	end

	// Scale the selected sum by the fraction bits
	assign dividend = DVD_BITS'(cmd.div_sel ? rep_rsum_q : rep_csum_q) << FRAC_BITS;

	beca_div #(
		.AREA_BITS(AREA_BITS),
		.QUO_BITS (QUO_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (rep_area_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quotient)
	);

	// Load the output registers; an empty region reports zeros
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			empty_q <= rep_empty_q;
			if (rep_empty_q) begin
				area_q   <= '0;
				out_cx_q <= '0;
				out_cy_q <= '0;
				for (int i = 0; i < 8; i++) begin
					out_ext_q[i] <= '0;
				end
			end else begin
				area_q   <= rep_area_q;
				out_cx_q <= cx_q;
				out_cy_q <= cy_q;
				for (int i = 0; i < 8; i++) begin
					out_ext_q[i] <= rep_ext_q[i];
				end
			end
		end
	end

	assign stat.empty    = live_empty;
	assign stat.div_done = div_done && !div_busy;

	assign area       = area_q;
	assign left_x     = out_ext_q[0];
	assign left_y     = out_ext_q[1];
	assign right_x    = out_ext_q[2];
	assign right_y    = out_ext_q[3];
	assign top_x      = out_ext_q[4];
	assign top_y      = out_ext_q[5];
	assign bottom_x   = out_ext_q[6];
	assign bottom_y   = out_ext_q[7];
	assign centroid_x = out_cx_q;
	assign centroid_y = out_cy_q;
	assign empty_res  = empty_q;

endmodule

// ===== hdl/beca_ctrl.sv =====
// ----------------------------------------------------------------------------
// beca_ctrl
// Controller: input handshake, action decode, divider sequencing and
// output valid.
// ----------------------------------------------------------------------------
`include "blob_extent_centroid_accumulator_defines.svh"

module beca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      action,
	output logic            out_valid,
	input  logic            out_ready,
	input  beca_pkg::stat_t stat,
	output beca_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_STARTX = 3'd1;
	localparam logic [2:0] ST_WAITX  = 3'd2;
	localparam logic [2:0] ST_WAITY  = 3'd3;
	localparam logic [2:0] ST_LOAD   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       in_fire;
	logic       rep_fire;
	logic       in_wait;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign rep_fire = in_fire && (action == beca_pkg::ACT_REPORT);
	assign in_wait  = (state_q == ST_WAITX) || (state_q == ST_WAITY);

	// Decode actions and step through the report sequence
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					priority if (action == beca_pkg::ACT_ADD) begin
						cmd.add = 1'b1;
					end else if (action == beca_pkg::ACT_CLEAR) begin
						cmd.clr = 1'b1;
					end else if (action == beca_pkg::ACT_REPORT) begin
						cmd.snap = 1'b1;
						state_d  = stat.empty ? ST_LOAD : ST_STARTX;
					end else begin
						// drop the unused action code
						cmd = '0;
					end
				end
			end
			ST_STARTX: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAITX;
			end
			ST_WAITX: begin
				if (stat.div_done) begin
					cmd.cap_x     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_d       = ST_WAITY;
				end
			end
			ST_WAITY: begin
				cmd.div_sel = 1'b1;
				if (stat.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`BECA_ASSERT_SAME(a_no_overwrite, cmd.load, !out_valid_q || out_ready, "result overwritten")
	`BECA_ASSERT_SAME(a_done_in_wait, stat.div_done, in_wait, "divider done outside a wait")
	`BECA_ASSERT_NEXT(a_report_divides, rep_fire && !stat.empty, state_q == ST_STARTX, "no division")
	`BECA_ASSERT_NEXT(a_empty_skips, rep_fire && stat.empty, state_q == ST_LOAD, "empty report late")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Blob extent and centroid accumulator testbench
// Streams add, report and clear transactions into the accumulator. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// A local predictor tracks the region and queues one descriptor per report.
// Each descriptor that leaves the block is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

	localparam int COORD_W = 12;
	localparam int AREA_W  = 24;
	localparam int FRAC_W  = 4;
	localparam int CENT_W  = COORD_W + FRAC_W;
	localparam logic [COORD_W-1:0] COORD_TOP = '1;
	// Action code with no meaning: the block must ignore it
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 800;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [1:0]         act;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
	} pixel_item_t;

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [COORD_W-1:0] left_x;
		logic [COORD_W-1:0] left_y;
		logic [COORD_W-1:0] right_x;
		logic [COORD_W-1:0] right_y;
		logic [COORD_W-1:0] top_x;
		logic [COORD_W-1:0] top_y;
		logic [COORD_W-1:0] bottom_x;
		logic [COORD_W-1:0] bottom_y;
		logic [CENT_W-1:0]  cent_x;
		logic [CENT_W-1:0]  cent_y;
		logic               empty;
	} descriptor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = beca_pkg::ACT_ADD;
	logic [COORD_W-1:0] x = '0;
	logic [COORD_W-1:0] y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [AREA_W-1:0] area;
	logic [COORD_W-1:0] left_x, left_y, right_x, right_y;
	logic [COORD_W-1:0] top_x, top_y, bottom_x, bottom_y;
	logic [CENT_W-1:0] centroid_x, centroid_y;
	logic empty_res;

	// Pending stimulus and outstanding descriptors
	pixel_item_t pixel_items[$];
	descriptor_t descriptors_due[$];

	// Predicted region state
	logic [AREA_W-1:0]  rgn_count;
	logic               rgn_any;
	logic [COORD_W-1:0] rgn_lx, rgn_ly, rgn_rx, rgn_ry;
	logic [COORD_W-1:0] rgn_tx, rgn_ty, rgn_bx, rgn_by;
	logic [63:0]        col_sum, row_sum;

	// Statistics and bookkeeping
	int mismatches = 0;
	int points_added = 0;
	int clears_seen = 0;
	int empties_seen = 0;
	int items_in = 0;
	int results_seen = 0;
	int send_wait = 0;
	int recv_wait = 0;
	int long_hold = 0;
	int wait_draw;
	logic send_burst = 1'b0;
	logic recv_burst = 1'b0;
	logic hold_done = 1'b0;
	logic next_ready;
	pixel_item_t next_item;

	blob_extent_centroid_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.x(x),
		.y(y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.area(area),
		.left_x(left_x),
		.left_y(left_y),
		.right_x(right_x),
		.right_y(right_y),
		.top_x(top_x),
		.top_y(top_y),
		.bottom_x(bottom_x),
		.bottom_y(bottom_y),
		.centroid_x(centroid_x),
		.centroid_y(centroid_y),
		.empty_res(empty_res)
	);

	// Clock and reset
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Empty the predicted region
	task automatic clear_region();
		rgn_count = '0;
		rgn_any = 1'b0;
		{rgn_lx, rgn_ly, rgn_rx, rgn_ry} = '0;
		{rgn_tx, rgn_ty, rgn_bx, rgn_by} = '0;
		col_sum = '0;
		row_sum = '0;
	endtask

	// Advance the predicted region by one accepted transaction
	task automatic fold_item(pixel_item_t it);
		descriptor_t d;
		case (it.act)
			beca_pkg::ACT_ADD: begin
				// strict compares keep the earlier point on ties
				if (!rgn_any || it.px < rgn_lx) begin
					rgn_lx = it.px;
					rgn_ly = it.py;
				end
				if (!rgn_any || it.px > rgn_rx) begin
					rgn_rx = it.px;
					rgn_ry = it.py;
				end
				if (!rgn_any || it.py < rgn_ty) begin
					rgn_tx = it.px;
					rgn_ty = it.py;
				end
				if (!rgn_any || it.py > rgn_by) begin
					rgn_bx = it.px;
					rgn_by = it.py;
				end
				rgn_any = 1'b1;
				// freeze count and sums once the count saturates
				if (rgn_count != '1) begin
					rgn_count = rgn_count + 1'b1;
					col_sum = col_sum + it.px;
					row_sum = row_sum + it.py;
				end
				points_added++;
			end
			beca_pkg::ACT_CLEAR: begin
				clear_region();
				clears_seen++;
			end
			beca_pkg::ACT_REPORT: begin
				d = '0;
				if (!rgn_any || rgn_count == '0) begin
					d.empty = 1'b1;
				end else begin
					d.area = rgn_count;
					d.left_x = rgn_lx;
					d.left_y = rgn_ly;
					d.right_x = rgn_rx;
					d.right_y = rgn_ry;
					d.top_x = rgn_tx;
					d.top_y = rgn_ty;
					d.bottom_x = rgn_bx;
					d.bottom_y = rgn_by;
					d.cent_x = CENT_W'((col_sum << FRAC_W) / 64'(rgn_count));
					d.cent_y = CENT_W'((row_sum << FRAC_W) / 64'(rgn_count));
				end
				descriptors_due.push_back(d);
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Compare one descriptor taken from the block with the oldest prediction
	task automatic check_descriptor();
		descriptor_t got;
		descriptor_t want;
		got = '{area, left_x, left_y, right_x, right_y, top_x, top_y,
			bottom_x, bottom_y, centroid_x, centroid_y, empty_res};
		if (descriptors_due.size() == 0) begin
			flag_mismatch("descriptor with none outstanding", 1, 0);
			return;
		end
		want = descriptors_due.pop_front();
		if (want.empty)
			empties_seen++;
		if (got.area !== want.area) flag_mismatch("area", got.area, want.area);
		if (got.left_x !== want.left_x) flag_mismatch("left_x", got.left_x, want.left_x);
		if (got.left_y !== want.left_y) flag_mismatch("left_y", got.left_y, want.left_y);
		if (got.right_x !== want.right_x) flag_mismatch("right_x", got.right_x, want.right_x);
		if (got.right_y !== want.right_y) flag_mismatch("right_y", got.right_y, want.right_y);
		if (got.top_x !== want.top_x) flag_mismatch("top_x", got.top_x, want.top_x);
		if (got.top_y !== want.top_y) flag_mismatch("top_y", got.top_y, want.top_y);
		if (got.bottom_x !== want.bottom_x)
			flag_mismatch("bottom_x", got.bottom_x, want.bottom_x);
		if (got.bottom_y !== want.bottom_y)
			flag_mismatch("bottom_y", got.bottom_y, want.bottom_y);
		if (got.cent_x !== want.cent_x) flag_mismatch("centroid_x", got.cent_x, want.cent_x);
		if (got.cent_y !== want.cent_y) flag_mismatch("centroid_y", got.cent_y, want.cent_y);
		if (got.empty !== want.empty) flag_mismatch("empty_res", got.empty, want.empty);
	endtask

	task automatic queue_item(logic [1:0] act, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		pixel_items.push_back('{act, px, py});
	endtask

	// Coordinate inside a wrapping box, with the edges of the frame mixed in
	function automatic logic [COORD_W-1:0] draw_coord(int base, int span);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COORD_TOP;
			default: return COORD_W'(base + $urandom_range(0, span - 1));
		endcase
	endfunction

	// Build the stimulus: directed cases first, then random regions
	initial begin : build_stimulus
		int random_count;
		int n_pts;
		int span_x;
		int span_y;
		int base_x;
		int base_y;
		int spans[4];
		logic [1:0] act;
		spans = '{1, 4, 64, 4096};
		clear_region();

		// empty region straight after reset, unused code, clear on empty
		queue_item(beca_pkg::ACT_REPORT, COORD_TOP, COORD_TOP);
		queue_item(ACT_UNUSED, COORD_TOP, COORD_TOP);
		queue_item(beca_pkg::ACT_REPORT, '0, '0);
		queue_item(beca_pkg::ACT_CLEAR, COORD_TOP, COORD_TOP);
		queue_item(beca_pkg::ACT_REPORT, '0, '0);
		// first point sets every extreme
		queue_item(beca_pkg::ACT_ADD, 12'h800, 12'h800);
		queue_item(beca_pkg::ACT_REPORT, '0, '0);
		// frame corners, with ties on every extreme
		queue_item(beca_pkg::ACT_ADD, '0, COORD_TOP);
		queue_item(beca_pkg::ACT_ADD, '0, '0);
		queue_item(beca_pkg::ACT_ADD, COORD_TOP, '0);
		queue_item(beca_pkg::ACT_ADD, COORD_TOP, COORD_TOP);
		queue_item(beca_pkg::ACT_ADD, '0, '0);
		queue_item(ACT_UNUSED, 12'h4d2, 12'h237);
		// report twice: the first must leave the region untouched
		queue_item(beca_pkg::ACT_REPORT, '0, '0);
		queue_item(beca_pkg::ACT_REPORT, COORD_TOP, COORD_TOP);
		queue_item(beca_pkg::ACT_ADD, COORD_TOP, COORD_TOP);
		queue_item(beca_pkg::ACT_REPORT, '0, '0);
		// clear, then a fresh region with duplicate points
		queue_item(beca_pkg::ACT_CLEAR, '0, '0);
		queue_item(beca_pkg::ACT_ADD, COORD_TOP, '0);
		queue_item(beca_pkg::ACT_ADD, COORD_TOP, '0);
		queue_item(beca_pkg::ACT_REPORT, '0, '0);
		queue_item(beca_pkg::ACT_CLEAR, '0, '0);
		queue_item(beca_pkg::ACT_REPORT, '0, '0);

		// random part: mostly well-formed regions, some noise
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				act = 2'($urandom_range(0, 3));
				queue_item(act, COORD_W'($urandom), COORD_W'($urandom));
				if (act != ACT_UNUSED)
					random_count++;
			end else begin
				base_x = $urandom_range(0, 4095);
				base_y = $urandom_range(0, 4095);
				span_x = spans[$urandom_range(0, 3)];
				span_y = spans[$urandom_range(0, 3)];
				n_pts = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 16);
				// now and then keep the old region going
				if ($urandom_range(0, 3) != 0) begin
					queue_item(beca_pkg::ACT_CLEAR, COORD_W'($urandom),
						COORD_W'($urandom));
					random_count++;
				end
				repeat (n_pts) begin
					queue_item(beca_pkg::ACT_ADD, draw_coord(base_x, span_x),
						draw_coord(base_y, span_y));
					random_count++;
				end
				queue_item(beca_pkg::ACT_REPORT, COORD_W'($urandom), COORD_W'($urandom));
				random_count++;
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 5)) begin
						queue_item(beca_pkg::ACT_ADD, draw_coord(base_x, span_x),
							draw_coord(base_y, span_y));
						random_count++;
					end
					queue_item(beca_pkg::ACT_REPORT, '0, '0);
					random_count++;
				end
			end
		end
	end

	// Driver: present queued transactions, idling between them at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= beca_pkg::ACT_ADD;
			x <= '0;
			y <= '0;
			send_wait <= 0;
			send_burst <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				fold_item('{action, x, y});
				items_in <= items_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pixel_items.size() != 0) begin
					next_item = pixel_items.pop_front();
					in_valid <= 1'b1;
					action <= next_item.act;
					x <= next_item.px;
					y <= next_item.py;
					send_wait <= send_burst ? 0 : $urandom_range(0, 9);
				end else begin
					in_valid <= 1'b0;
				end
				// switch between idling and back-to-back stretches
				if ($urandom_range(0, 47) == 0)
					send_burst <= !send_burst;
			end
		end
	end

	// Monitor: take descriptors, stall at random, hold off once for long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			recv_burst <= 1'b0;
			long_hold <= 0;
			hold_done <= 1'b0;
			results_seen <= 0;
		end else begin
			next_ready = 1'b1;
			if (out_valid && out_ready) begin
				check_descriptor();
				results_seen <= results_seen + 1;
				if (!hold_done && results_seen == 29) begin
					// long hold-off so the block backs up and stalls its input
					long_hold <= LONG_HOLD;
					hold_done <= 1'b1;
					next_ready = 1'b0;
				end else begin
					wait_draw = recv_burst ? 0 : $urandom_range(0, 9);
					recv_wait <= wait_draw;
					next_ready = (wait_draw == 0);
				end
				if ($urandom_range(0, 15) == 0)
					recv_burst <= !recv_burst;
			end else if (long_hold != 0) begin
				long_hold <= long_hold - 1;
				next_ready = (long_hold == 1);
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				next_ready = (recv_wait == 1);
			end
			out_ready <= next_ready;
		end
	end

	// Run until everything is sent and every descriptor has come back
	initial begin
		@(posedge arst_n);
		while (pixel_items.size() != 0 || in_valid || descriptors_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d transactions in: %0d points, %0d clears.",
			items_in, points_added, clears_seen);
		$display("Checked %0d descriptors, %0d of them on an empty region.",
			results_seen, empties_seen);
		if (mismatches == 0 && descriptors_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#(12 * LIMIT_CYCLES);
		$display("testbench failed");
		$finish;
	end

endmodule
